// File: sv/ltvb_pkg.sv
// shared constants and types for the trilinear voxel blend core
`timescale 1ns / 1ps

package ltvb_pkg;

    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int VOXEL_INDEX_BITS = 24;
    localparam int CORNER_COUNT     = 8;
    localparam int SAMPLE_BITS      = 8;
    localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 1;
    localparam int PROD_BITS        = WEIGHT_BITS + SAMPLE_BITS;
    localparam int SUM2_BITS        = PROD_BITS + 1;
    localparam int SUM4_BITS        = PROD_BITS + 2;
    localparam int SUM8_BITS        = PROD_BITS + 3;
    localparam int WHOLE_BITS       = SUM8_BITS - WEIGHT_FRAC_BITS;
    localparam int VALUE_BITS       = SAMPLE_BITS;

    localparam int IN_FIELD_BITS    = CORNER_COUNT * WEIGHT_BITS
                                    + CORNER_COUNT * SAMPLE_BITS + VOXEL_INDEX_BITS;
    localparam int IN_TDATA_BITS    = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS   = VALUE_BITS + VOXEL_INDEX_BITS;
    localparam int OUT_TDATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int SAMPLES_LSB      = CORNER_COUNT * WEIGHT_BITS;
    localparam int INDEX_LSB        = SAMPLES_LSB + CORNER_COUNT * SAMPLE_BITS;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    typedef logic [CORNER_COUNT-1:0][WEIGHT_BITS-1:0]   t_weight_arr;
    typedef logic [CORNER_COUNT-1:0][SAMPLE_BITS-1:0]   t_sample_arr;
    typedef logic [CORNER_COUNT-1:0][PROD_BITS-1:0]     t_prod_arr;
    typedef logic [CORNER_COUNT/2-1:0][SUM2_BITS-1:0]   t_sum2_arr;
    typedef logic [CORNER_COUNT/4-1:0][SUM4_BITS-1:0]   t_sum4_arr;
    typedef logic [VOXEL_INDEX_BITS-1:0]                t_index;

endpackage

// File: sv/ltvb_mul.sv
// first stage: eight weight by sample products
`timescale 1ns / 1ps

module ltvb_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ltvb_pkg::t_weight_arr i_weight,
    input  ltvb_pkg::t_sample_arr i_samples,
    input  ltvb_pkg::t_index      i_index,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ltvb_pkg::t_prod_arr   o_prod,
    output ltvb_pkg::t_index      o_index
);
    import ltvb_pkg::*;

    logic        r_valid;
    t_prod_arr   r_prod;
    t_prod_arr   n_prod;
    t_index      r_index;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        for (int n = 0; n < CORNER_COUNT; n++) begin
            n_prod[n] = PROD_BITS'(i_weight[n]) * PROD_BITS'(i_samples[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod  <= n_prod;
            r_index <= i_index;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_index = r_index;

endmodule

// File: sv/ltvb_add.sv
// second and third stages: pair sums, then quad sums
`timescale 1ns / 1ps

module ltvb_add (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ltvb_pkg::t_prod_arr  i_prod,
    input  ltvb_pkg::t_index     i_index,
    output logic                o_valid,
    input  logic                i_ready,
    output ltvb_pkg::t_sum4_arr  o_sum4,
    output ltvb_pkg::t_index     o_index
);
    import ltvb_pkg::*;

    logic      r_valid2;
    t_sum2_arr r_sum2;
    t_sum2_arr n_sum2;
    t_index    r_index2;
    logic      r_valid3;
    t_sum4_arr r_sum4;
    t_sum4_arr n_sum4;
    t_index    r_index3;
    logic      w_ready3;

    assign w_ready3 = !r_valid3 || i_ready;
    assign o_ready  = !r_valid2 || w_ready3;

    always_comb begin
        for (int n = 0; n < CORNER_COUNT / 2; n++) begin
            n_sum2[n] = SUM2_BITS'(i_prod[2*n]) + SUM2_BITS'(i_prod[2*n+1]);
        end
        for (int n = 0; n < CORNER_COUNT / 4; n++) begin
            n_sum4[n] = SUM4_BITS'(r_sum2[2*n]) + SUM4_BITS'(r_sum2[2*n+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid2 <= i_valid;
            end
            if (w_ready3) begin
                r_valid3 <= r_valid2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sum2   <= n_sum2;
            r_index2 <= i_index;
        end
        if (w_ready3 && r_valid2) begin
            r_sum4   <= n_sum4;
            r_index3 <= r_index2;
        end
    end

    assign o_valid = r_valid3;
    assign o_sum4  = r_sum4;
    assign o_index = r_index3;

endmodule

// File: sv/lut_trilinear_voxel_blend_core.sv
// top level of the trilinear voxel blend core: beat unpacking, final sum and clamp
`timescale 1ns / 1ps

// Blends eight 8-bit corner samples with eight unsigned Q1.16 weights per beat and
// returns the integer part of the weighted sum, clamped at 255, with the voxel index.
// One beat is accepted every clock cycle when the output side keeps up. Four register
// stages lie between input beat and output beat: products, pair sums, quad sums,
// and the final sum with clamp in the output register. Backpressure stalls only the
// stages that hold data, so empty stages still take new beats while a finished
// result waits.

module lut_trilinear_voxel_blend_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // weight_0 .. weight_7, corner_samples, dest_index
    input  logic [ltvb_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // voxel_value, voxel_index
    output logic [ltvb_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata
);
    import ltvb_pkg::*;

    t_weight_arr w_weight;
    t_sample_arr w_samples;
    t_index      w_in_index;

    logic        w_mul_valid;
    logic        w_mul_ready;
    t_prod_arr   w_prod;
    t_index      w_mul_index;

    logic        w_add_valid;
    logic        w_add_ready;
    t_sum4_arr   w_sum4;
    t_index      w_add_index;

    logic [SUM8_BITS-1:0]  w_sum8;
    logic [WHOLE_BITS-1:0] w_whole;
    logic [VALUE_BITS-1:0] n_value;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_value;
    t_index                r_index;

    always_comb begin
        for (int n = 0; n < CORNER_COUNT; n++) begin
            w_weight[n]  = s_axis_tdata[n*WEIGHT_BITS +: WEIGHT_BITS];
            w_samples[n] = s_axis_tdata[SAMPLES_LSB + n*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    assign w_in_index = s_axis_tdata[INDEX_LSB +: VOXEL_INDEX_BITS];

    ltvb_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_weight  (w_weight),
        .i_samples (w_samples),
        .i_index   (w_in_index),
        .o_valid   (w_mul_valid),
        .i_ready   (w_mul_ready),
        .o_prod    (w_prod),
        .o_index   (w_mul_index)
    );

    ltvb_add u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_valid),
        .o_ready (w_mul_ready),
        .i_prod  (w_prod),
        .i_index (w_mul_index),
        .o_valid (w_add_valid),
        .i_ready (w_add_ready),
        .o_sum4  (w_sum4),
        .o_index (w_add_index)
    );

    // final sum, keep integer part, clamp
    assign w_sum8  = SUM8_BITS'(w_sum4[0]) + SUM8_BITS'(w_sum4[1]);
    assign w_whole = w_sum8[SUM8_BITS-1:WEIGHT_FRAC_BITS];
    assign n_value = (w_whole > WHOLE_BITS'(VALUE_MAX)) ? VALUE_MAX
                                                         : w_whole[VALUE_BITS-1:0];

    assign w_add_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_add_ready) begin
            r_out_valid <= w_add_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_add_ready && w_add_valid) begin
            r_value <= n_value;
            r_index <= w_add_index;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_BITS'({r_index, r_value});

`ifndef SYNTHESIS
    // an empty output register lets every stage take a beat
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> (w_add_ready && w_mul_ready && s_axis_tready))
        else $error("ready chain blocked with empty output stage");

    // an accepted beat always lands in the product stage
    a_mul_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> w_mul_valid)
        else $error("accepted beat lost at product stage");

    // a sum past the top of the range is clamped
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_add_valid && w_add_ready && (w_whole > WHOLE_BITS'(VALUE_MAX)))
        |=> (r_value == VALUE_MAX))
        else $error("overflowing sum not clamped");

    // a stalled result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> ($stable(r_value) && $stable(r_index)))
        else $error("stalled result changed");
`endif

endmodule

// File: tb/sv/tb.sv
// testbench for lut_trilinear_voxel_blend_core: stream driver, predictor and result checker
`timescale 1ns / 1ps

module tb;
    import ltvb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 400;
    localparam int RANDOM_ITEMS = 1400;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << WEIGHT_FRAC_BITS;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        t_index                index;
    } t_voxel;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} t_rx_mode;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // weight_0 .. weight_7, corner_samples, dest_index
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // voxel_value, voxel_index
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    logic [IN_TDATA_BITS-1:0]  lut_entries[$];
    t_voxel                    expected_voxels[$];

    bit       beat_taken = 1'b0;
    int       beats_in = 0;
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       mode_left = 0;
    int       rx_phase = 0;
    t_rx_mode rx_mode = RX_ALWAYS;
    logic     next_ready;
    t_voxel   got_voxel;
    t_voxel   want_voxel;

    lut_trilinear_voxel_blend_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_voxel blend_voxel(input logic [IN_TDATA_BITS-1:0] beat);
        t_weight_arr           w;
        t_sample_arr           s;
        logic [SUM8_BITS-1:0]  acc;
        logic [WHOLE_BITS-1:0] whole;
        t_voxel                v;
        w   = beat[SAMPLES_LSB-1:0];
        s   = beat[INDEX_LSB-1:SAMPLES_LSB];
        acc = '0;
        for (int n = 0; n < CORNER_COUNT; n++) begin
            acc += SUM8_BITS'(w[n]) * SUM8_BITS'(s[n]);
        end
        whole   = acc[SUM8_BITS-1:WEIGHT_FRAC_BITS];
        v.value = (whole > WHOLE_BITS'(VALUE_MAX)) ? VALUE_MAX : whole[VALUE_BITS-1:0];
        v.index = beat[INDEX_LSB +: VOXEL_INDEX_BITS];
        return v;
    endfunction

    function automatic void add_entry(input t_weight_arr w, input t_sample_arr s,
                                      input t_index idx);
        lut_entries.insert(lut_entries.size(), IN_TDATA_BITS'({idx, s, w}));
    endfunction

    function automatic void report_mismatch(input string what, input longint want,
                                            input longint got);
        mismatch_count++;
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    endfunction

    // stimulus, reset and end of run
    initial begin
        t_weight_arr       w;
        t_sample_arr       smp;
        longint unsigned   fr[3];
        longint unsigned   part;
        int                kind;

        // all weights zero
        add_entry('0, '1, '0);
        // largest weights on full samples, and on empty samples
        add_entry('1, '1, '1);
        add_entry('1, '0, 24'h000001);
        // each corner alone at exactly one
        for (int n = 0; n < CORNER_COUNT; n++) begin
            w    = '0;
            w[n] = WEIGHT_ONE;
            add_entry(w, 64'h8F7E6D5C4B3A2918, t_index'(n * 24'h111111));
        end
        // even split, just under, just over
        for (int n = 0; n < CORNER_COUNT; n++) w[n] = WEIGHT_BITS'(WEIGHT_ONE / 8);
        add_entry(w, '1, 24'hAAAAAA);
        for (int n = 0; n < CORNER_COUNT; n++) w[n] = WEIGHT_BITS'(WEIGHT_ONE / 8 - 1);
        add_entry(w, '1, 24'h555555);
        for (int n = 0; n < CORNER_COUNT; n++) w[n] = WEIGHT_BITS'(WEIGHT_ONE / 8 + 1);
        add_entry(w, '1, 24'h800000);
        // weights adding to two on mid samples
        for (int n = 0; n < CORNER_COUNT; n++) w[n] = WEIGHT_BITS'(WEIGHT_ONE / 4);
        add_entry(w, {8{8'd200}}, 24'h7FFFFF);
        // one corner just below one, and a single lsb of weight
        w    = '0;
        w[3] = WEIGHT_BITS'(WEIGHT_ONE - 1);
        add_entry(w, '1, 24'h0F0F0F);
        w    = '0;
        w[7] = WEIGHT_BITS'(1);
        add_entry(w, '1, 24'hF0F0F0);
        // weights above one on small samples
        for (int n = 0; n < CORNER_COUNT; n++) w[n] = '1;
        add_entry(w, {8{8'd1}}, 24'h123456);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // genuine trilinear weights from three fractions
                for (int a = 0; a < 3; a++) begin
                    if ($urandom_range(0, 9) == 0)
                        fr[a] = $urandom_range(0, 1) ? 64'(WEIGHT_ONE) : 64'd0;
                    else
                        fr[a] = 64'($urandom_range(0, WEIGHT_ONE));
                end
                for (int n = 0; n < CORNER_COUNT; n++) begin
                    part = 64'd1;
                    for (int a = 0; a < 3; a++)
                        part *= ((n >> a) & 1) ? fr[a] : 64'(WEIGHT_ONE) - fr[a];
                    w[n] = WEIGHT_BITS'((part + 64'h8000_0000) >> 32);
                end
            end else if (kind < 85) begin
                for (int n = 0; n < CORNER_COUNT; n++)
                    w[n] = WEIGHT_BITS'($urandom_range(0, 131071));
            end else begin
                for (int n = 0; n < CORNER_COUNT; n++)
                    w[n] = WEIGHT_BITS'($urandom_range(0, WEIGHT_ONE));
            end
            smp = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
            add_entry(w, smp, t_index'($urandom_range(0, 24'hFFFFFF)));
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (lut_entries.size() != 0 || s_axis_tvalid || expected_voxels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // sender: bursts of beats with gaps in between
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || beat_taken)) begin
            if (gap_left > 0 || lut_entries.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tdata  <= lut_entries.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: changing stall patterns and one long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && beats_in >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                rx_phase++;
                case (rx_mode)
                    RX_ALWAYS:   next_ready = 1'b1;
                    RX_COIN:     next_ready = 1'($urandom_range(0, 1));
                    RX_MOSTLY:   next_ready = ($urandom_range(0, 9) != 0);
                    default:     next_ready = rx_phase[2];
                endcase
            end
            m_axis_tready <= next_ready;
        end
    end

    // input beats feed the predictor, output beats are checked in order
    always @(posedge i_clk) begin
        beat_taken = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                beat_taken = 1'b1;
                beats_in++;
                expected_voxels.insert(expected_voxels.size(), blend_voxel(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_voxel.value = m_axis_tdata[VALUE_BITS-1:0];
                got_voxel.index = m_axis_tdata[VALUE_BITS +: VOXEL_INDEX_BITS];
                if (expected_voxels.size() == 0) begin
                    report_mismatch("unexpected beat", 0, got_voxel);
                end else begin
                    want_voxel = expected_voxels.pop_front();
                    if (got_voxel.value !== want_voxel.value)
                        report_mismatch("voxel_value", want_voxel.value, got_voxel.value);
                    if (got_voxel.index !== want_voxel.index)
                        report_mismatch("voxel_index", want_voxel.index, got_voxel.index);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// File: sim.f
sv/ltvb_pkg.sv
sv/ltvb_mul.sv
sv/ltvb_add.sv
sv/lut_trilinear_voxel_blend_core.sv
tb/sv/tb.sv
